// File: src/triangular_solve_3x3_defines.svh
// assertion macros used by the triangular solver checker
`ifndef TRIANGULAR_SOLVE_3X3_DEFINES_SVH
`define TRIANGULAR_SOLVE_3X3_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define TSV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// invariant checked at every rising clock edge outside reset
`define TSV_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// File: src/tsv_pkg.sv
// shared types and constants of the triangular solver
package tsv_pkg;

	// cycles from an accepted start to its done strobe
	localparam int LATENCY = 110;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_TRI   = 2'd1;
	localparam logic [1:0] ST_ZERO_DIAG = 2'd2;
	localparam logic [1:0] ST_OVERFLOW  = 2'd3;

	typedef struct packed {
		logic [8:0][31:0] a;
		logic [2:0][31:0] b;
		logic [2:0][31:0] x;
		logic             lower;
		logic [1:0]       status;
		logic             ovf;
	} item_t;

	typedef struct packed {
		item_t       item;
		logic        neg;
		logic        big;
		logic [31:0] rem;
		logic [31:0] nlow;
		logic [31:0] q;
		logic [31:0] ud;
	} div_t;

endpackage

// File: src/tsv_div_cell.sv
// one restoring division step: one quotient bit per cell
module tsv_div_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_in,
	input  tsv_pkg::div_t d_in,
	output logic         valid_out,
	output tsv_pkg::div_t d_out
);
	import tsv_pkg::*;

	logic [32:0] trial;
	logic [32:0] diff;
	logic        take;
	div_t        nxt;
	logic        valid_q;
	div_t        data_q;

	always_comb begin
		trial = {d_in.rem, d_in.nlow[31]};
		diff = trial - {1'b0, d_in.ud};
		take = (trial >= {1'b0, d_in.ud});
		nxt = d_in;
		nxt.rem = take ? diff[31:0] : trial[31:0];
		nxt.nlow = {d_in.nlow[30:0], 1'b0};
		nxt.q = {d_in.q[30:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign valid_out = valid_q;
	assign d_out = data_q;

endmodule

// File: src/tsv_row.sv
// solves one row: products, residual, divider chain, saturation
module tsv_row #(
	parameter int FRAC_BITS = 16,
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_in,
	input  tsv_pkg::item_t item_in,
	output logic          valid_out,
	output tsv_pkg::item_t item_out
);
	import tsv_pkg::*;

	localparam int RW = 66 - FRAC_BITS;
	localparam int NW = RW - 1 + FRAC_BITS;
	localparam int CELLS = 32;

	// operand selection
	logic [31:0] op_a0, op_x0, op_a1, op_x1;
	logic [1:0]  row_in;

	always_comb begin
		op_a0 = '0;
		op_x0 = '0;
		op_a1 = '0;
		op_x1 = '0;
		row_in = item_in.lower ? 2'(STEP) : 2'(2 - STEP);
		case (STEP)
			1: begin
				if (item_in.lower) begin
					op_a0 = item_in.a[3];
					op_x0 = item_in.x[0];
				end else begin
					op_a0 = item_in.a[5];
					op_x0 = item_in.x[2];
				end
			end
			2: begin
				if (item_in.lower) begin
					op_a0 = item_in.a[6];
					op_x0 = item_in.x[0];
					op_a1 = item_in.a[7];
					op_x1 = item_in.x[1];
				end else begin
					op_a0 = item_in.a[1];
					op_x0 = item_in.x[1];
					op_a1 = item_in.a[2];
					op_x1 = item_in.x[2];
				end
			end
			default: begin
			end
		endcase
	end

	// stage 1: products
	logic               valid_s1;
	item_t              item_s1;
	logic [1:0]         row_s1;
	logic signed [63:0] prod0_s1, prod1_s1;

	always_ff @(posedge clk) begin
		item_s1 <= item_in;
		row_s1 <= row_in;
		prod0_s1 <= 64'($signed(op_a0)) * 64'($signed(op_x0));
		prod1_s1 <= 64'($signed(op_a1)) * 64'($signed(op_x1));
	end

	// stage 2: residual
	logic signed [63:0]   sh0, sh1;
	logic signed [RW-1:0] acc, bx;
	logic [31:0]          brow, diag;

	always_comb begin
		sh0 = prod0_s1 >>> FRAC_BITS;
		sh1 = prod1_s1 >>> FRAC_BITS;
		acc = $signed(sh0[RW-1:0]) + $signed(sh1[RW-1:0]);
		brow = item_s1.b[row_s1];
		bx = $signed({{(RW - 32){brow[31]}}, brow});
		case (row_s1)
			2'd0: diag = item_s1.a[0];
			2'd1: diag = item_s1.a[4];
			default: diag = item_s1.a[8];
		endcase
	end

	logic                 valid_s2;
	item_t                item_s2;
	logic signed [RW-1:0] r_s2;
	logic [31:0]          d_s2;

	always_ff @(posedge clk) begin
		item_s2 <= item_s1;
		r_s2 <= bx - acc;
		d_s2 <= diag;
	end

	// stage 3: magnitudes and divider set-up
	logic [RW-1:0]    mag;
	logic [NW-1:0]    num;
	logic [31:0]      ud;
	logic [NW-33:0]   hi;
	logic             big;
	div_t             div_init;

	always_comb begin
		mag = r_s2[RW-1] ? RW'(-r_s2) : RW'(r_s2);
		num = {mag[RW-2:0], {FRAC_BITS{1'b0}}};
		ud = d_s2[31] ? (~d_s2 + 32'd1) : d_s2;
		hi = num[NW-1:32];
		big = (hi >= (NW - 32)'(ud));
		div_init.item = item_s2;
		div_init.neg = r_s2[RW-1] ^ d_s2[31];
		div_init.big = big;
		div_init.rem = big ? 32'd0 : hi[31:0];
		div_init.nlow = num[31:0];
		div_init.q = '0;
		div_init.ud = ud;
	end

	logic valid_s3;
	div_t div_s3;

	always_ff @(posedge clk) begin
		div_s3 <= div_init;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// divider chain
	logic [CELLS:0] cv;
	div_t           cd [CELLS+1];

	assign cv[0] = valid_s3;
	assign cd[0] = div_s3;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		tsv_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (cv[k]),
			.d_in     (cd[k]),
			.valid_out(cv[k+1]),
			.d_out    (cd[k+1])
		);
	end

	// stage 4: sign and saturation
	div_t        fin;
	logic [31:0] lim, qv, xv;
	logic        sat;
	logic [1:0]  row_out;
	item_t       item_nxt;

	always_comb begin
		fin = cd[CELLS];
		lim = fin.neg ? 32'h8000_0000 : 32'h7fff_ffff;
		sat = fin.big || (fin.q > lim);
		qv = sat ? lim : fin.q;
		xv = fin.neg ? (~qv + 32'd1) : qv;
		row_out = fin.item.lower ? 2'(STEP) : 2'(2 - STEP);
		item_nxt = fin.item;
		item_nxt.x[row_out] = xv;
		item_nxt.ovf = fin.item.ovf | sat;
	end

	logic  valid_s4;
	item_t item_s4;

	always_ff @(posedge clk) begin
		item_s4 <= item_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= cv[CELLS];
		end
	end

	assign valid_out = valid_s4;
	assign item_out = item_s4;

endmodule

// File: src/triangular_solve_3x3.sv
// top level of the 3x3 triangular solver
// usage:
//  - raise start with a matrix a00..a22 and a vector b0..b2 in signed fixed point
//  - a transfer happens at each rising edge with start high and busy low
//  - busy stays low: a new system can be taken in every cycle
//  - one result per system appears on x0..x2 and status with done high
//    for exactly one cycle
//  - pipeline: one input register, three row units (product, residual,
//    set-up, 32 one-bit division cells, saturation) and one output
//    register; the 32-cell divider per row sets the depth
//  - throughput: one system per cycle, every stage a register
//  - status: 0 ok, 1 not triangular, 2 zero diagonal, 3 saturated
//  - a zero top-right entry selects forward substitution, else a zero
//    bottom-left entry selects back substitution
//  - reset clears all valid flags, so nothing in flight is delivered
//  - the receiver cannot stall: done is a strobe and results must be taken
module triangular_solve_3x3 #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] a00,
	input  logic signed [31:0] a01,
	input  logic signed [31:0] a02,
	input  logic signed [31:0] a10,
	input  logic signed [31:0] a11,
	input  logic signed [31:0] a12,
	input  logic signed [31:0] a20,
	input  logic signed [31:0] a21,
	input  logic signed [31:0] a22,
	input  logic signed [31:0] b0,
	input  logic signed [31:0] b1,
	input  logic signed [31:0] b2,
	output logic               done,
	output logic signed [31:0] x0,
	output logic signed [31:0] x1,
	output logic signed [31:0] x2,
	output logic [1:0]         status
);
	import tsv_pkg::*;

	// always ready: the pipeline never stalls
	assign busy = 1'b0;

	// classify the system on the way in
	item_t item_new;

	always_comb begin
		item_new.a = {a22, a21, a20, a12, a11, a10, a02, a01, a00};
		item_new.b = {b2, b1, b0};
		item_new.x = '0;
		item_new.lower = (a02 == 32'sd0);
		item_new.ovf = 1'b0;
		if (a02 != 32'sd0 && a20 != 32'sd0) begin
			item_new.status = ST_NOT_TRI;
		end else if (a00 == 32'sd0 || a11 == 32'sd0 || a22 == 32'sd0) begin
			item_new.status = ST_ZERO_DIAG;
		end else begin
			item_new.status = ST_OK;
		end
	end

	// input register
	logic  in_valid_q;
	item_t in_item_q;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			in_item_q <= item_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else begin
			in_valid_q <= start && !busy;
		end
	end

	// three row units in a row; each solves one unknown
	logic [3:0] rv;
	item_t      ri [4];

	assign rv[0] = in_valid_q;
	assign ri[0] = in_item_q;

	for (genvar k = 0; k < 3; k++) begin : g_row
		tsv_row #(
			.FRAC_BITS(FRAC_BITS),
			.STEP     (k)
		) u_row (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (rv[k]),
			.item_in  (ri[k]),
			.valid_out(rv[k+1]),
			.item_out (ri[k+1])
		);
	end

	// output register: errors force zeros, overflow sets its code
	logic        done_q;
	logic [31:0] x0_q, x1_q, x2_q;
	logic [1:0]  status_q;

	always_ff @(posedge clk) begin
		if (ri[3].status != ST_OK) begin
			x0_q <= '0;
			x1_q <= '0;
			x2_q <= '0;
			status_q <= ri[3].status;
		end else begin
			x0_q <= ri[3].x[0];
			x1_q <= ri[3].x[1];
			x2_q <= ri[3].x[2];
			status_q <= ri[3].ovf ? ST_OVERFLOW : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rv[3];
		end
	end

	assign done = done_q;
	assign x0 = $signed(x0_q);
	assign x1 = $signed(x1_q);
	assign x2 = $signed(x2_q);
	assign status = status_q;

endmodule

// File: src/tsv_checker.sv
// port-level checks of the triangular solver, bound to the top level
`include "triangular_solve_3x3_defines.svh"

module tsv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] x0,
	input logic signed [31:0] x1,
	input logic signed [31:0] x2,
	input logic [1:0]         status
);
	import tsv_pkg::*;

	logic is_err;
	logic all_zero;
	logic any_sat;

	// error codes carry an all-zero solution
	assign is_err = (status == ST_NOT_TRI) || (status == ST_ZERO_DIAG);
	assign all_zero = (x0 == 32'sd0) && (x1 == 32'sd0) && (x2 == 32'sd0);

	// a saturated row leaves one of the two limits on its output
	assign any_sat = (x0 == 32'sh7fff_ffff) || (x0 == 32'sh8000_0000) ||
		(x1 == 32'sh7fff_ffff) || (x1 == 32'sh8000_0000) ||
		(x2 == 32'sh7fff_ffff) || (x2 == 32'sh8000_0000);

	`TSV_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
	`TSV_ASSERT_IMP(a_done_latency, done, $past(start, LATENCY), "done without start")
	`TSV_ASSERT_IMP(a_err_zero, done && is_err, all_zero, "error result not zero")
	`TSV_ASSERT_IMP(a_ovf_sat, done && status == ST_OVERFLOW, any_sat, "overflow not saturated")

endmodule

bind triangular_solve_3x3 tsv_checker u_tsv_checker (.*);
